// File: design/spq_pkg.sv
// package for the sorted priority queue: sizes, codes and state type
`default_nettype none
package spq_pkg;
    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int ENTRY_W      = PAYLOAD_BITS + 12 + 8 + 16;

    localparam logic [11:0] MAX_GRADE_RST     = 12'd2560;
    localparam logic [7:0]  TOTAL_COURSES_RST = 8'd40;

    localparam logic       REQ_ENQ = 1'b0;
    localparam logic       REQ_DEQ = 1'b1;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic       CFG_MAX_GRADE = 1'b0;
    localparam logic       CFG_TOTAL     = 1'b1;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [11:0]             grade;
        logic [7:0]              courses;
        logic [15:0]             prio;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_SEARCH_RD, S_SEARCH, S_SHIFT_RD, S_SHIFT_WR,
        S_INSERT, S_DEQ_RD, S_DEQ_WR, S_HEAD_RD, S_HEAD, S_REPORT
    } state_t;
endpackage
`default_nettype wire

// File: design/sorted_priority_queue.sv
// top level: sorted priority queue held in one synchronous memory
`default_nettype none
// One command per start pulse; busy stays high until the result strobe.
// An enqueue computes its priority with a bit-serial restoring divider
// (one quotient bit per cycle), then walks the memory from the head to
// find its slot (a read state and a compare state per entry, the read
// data registered) and moves the tail down one entry at a time (a read
// state and a write state per moved entry). A dequeue moves every entry
// behind the head up one place (a read and a write state each). Entries
// move one at a time, set by the single memory port pair. The result comes
// out as a one-cycle strobe with no back pressure; configuration writes
// are always ready.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [15:0] payload,
    input  wire logic [11:0] avg_grade,
    input  wire logic [7:0]  courses_passed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    output logic             done,
    output logic [15:0]      head_payload,
    output logic [11:0]      head_grade,
    output logic [7:0]       head_courses,
    output logic [15:0]      head_priority,
    output logic [6:0]       occupancy,
    output logic             queue_empty,
    output logic [1:0]       status
);
    state_t state_reg, state_next;
    logic [11:0] max_grade_reg;
    logic [7:0]  total_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [4:0]  bit_reg, bit_next;
    logic        req_reg;
    entry_t      new_reg, new_next;
    logic [11:0] gm_reg;
    logic [7:0]  cm_reg;
    logic [16:0] num_reg, num_next;
    logic [19:0] den_reg, den_next;
    logic [20:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [1:0]  status_reg, status_next;
    entry_t      head_reg, head_next;
    logic        done_reg, done_next;

    entry_t mem [DEPTH];
    entry_t rd_data;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic   wr_en;
    entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_grade_reg <= MAX_GRADE_RST;
            total_reg     <= TOTAL_COURSES_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_GRADE)
                max_grade_reg <= cfg_data;
            else
                total_reg <= cfg_data[7:0];
        end
    end

    logic [11:0] gm_eff, g_clip;
    logic [7:0]  cm_eff, c_clip;
    logic [20:0] rem_sh;
    logic [20:0] prod_sum;
    always_comb
    begin
        gm_eff = (max_grade_reg == 12'd0) ? 12'd1 : max_grade_reg;
        cm_eff = (total_reg == 8'd0) ? 8'd1 : total_reg;
        g_clip = (new_reg.grade > gm_reg) ? gm_reg : new_reg.grade;
        c_clip = (new_reg.courses > cm_reg) ? cm_reg : new_reg.courses;
        prod_sum = 21'(g_clip) * 21'(cm_reg) + 21'(c_clip) * 21'(gm_reg);
        rem_sh = {rem_reg[19:0], num_reg[16]};
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        bit_next    = bit_reg;
        new_next    = new_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        status_next = status_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_en       = 1'b0;
        wr_data     = new_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.payload = payload[PAYLOAD_BITS-1:0];
                    new_next.grade   = avg_grade;
                    new_next.courses = courses_passed;
                    status_next      = ST_OK;
                    if (req_type == REQ_ENQ)
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_HEAD_RD;
                        end
                        else
                            state_next = S_MUL;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_HEAD_RD;
                    end
                    else
                    begin
                        ptr_next   = CNT_W'(1);
                        state_next = S_DEQ_RD;
                    end
                end
            end
            S_MUL:
            begin
                // sum is at most twice the divisor, so sum/4 is already a valid
                // remainder and only the last 17 dividend bits are left to shift in
                rem_next = {2'b00, prod_sum[20:2]};
                num_next = {prod_sum[1:0], 15'd0};
                den_next = 20'(gm_reg) * 20'(cm_reg);
                quo_next = '0;
                bit_next = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // quotient of sum*2^15 / den, one bit per cycle
                num_next = {num_reg[15:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd16)
                begin
                    pos_next   = '0;
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD:
            begin
                new_next.prio = quo_reg[16] ? 16'hFFFF : quo_reg[15:0];
                rd_addr = pos_reg[IDX_W-1:0];
                if (pos_reg == count_reg)
                begin
                    ptr_next   = count_reg;
                    state_next = S_INSERT;
                end
                else
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (rd_data.prio >= new_reg.prio)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_SEARCH_RD;
                end
                else
                begin
                    ptr_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // move entry ptr-1 to ptr, walking from the tail
                if (ptr_reg == pos_reg)
                    state_next = S_INSERT;
                else
                begin
                    rd_addr    = IDX_W'(ptr_reg - CNT_W'(1));
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                wr_data    = rd_data;
                ptr_next   = ptr_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IDX_W-1:0];
                wr_data    = new_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_HEAD_RD;
            end
            S_DEQ_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = S_DEQ_WR;
                end
            end
            S_DEQ_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(ptr_reg - CNT_W'(1));
                wr_data    = rd_data;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_DEQ_RD;
            end
            S_HEAD_RD:
            begin
                rd_addr    = '0;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                head_next  = (count_reg == '0) ? '0 : rd_data;
                done_next  = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        ptr_reg  <= ptr_next;
        bit_reg  <= bit_next;
        new_reg  <= new_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        head_reg <= head_next;
        if (state_reg == S_IDLE && start)
        begin
            gm_reg  <= gm_eff;
            cm_reg  <= cm_eff;
            req_reg <= req_type;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign head_payload  = 16'(head_reg.payload);
    assign head_grade    = head_reg.grade;
    assign head_courses  = head_reg.courses;
    assign head_priority = head_reg.prio;
    assign occupancy     = 7'(count_reg);
    assign queue_empty   = (count_reg == '0);
    assign status        = status_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");
    a_done_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_REPORT)
        else $error("strobe outside report state");
    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_FULL |-> $stable(count_reg))
        else $error("rejected enqueue changed count");
    a_deq_dec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_OK && req_reg == REQ_DEQ |->
        count_reg == $past(count_reg))
        else $error("count moved at report");
endmodule
`default_nettype wire

// File: test/spq_checker.sv
// checker for the sorted priority queue: watches transfers, predicts results and compares
`timescale 1ns / 100ps
module spq_checker
    import spq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        req_type,
    input  wire logic [15:0] payload,
    input  wire logic [11:0] avg_grade,
    input  wire logic [7:0]  courses_passed,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    input  wire logic        done,
    input  wire logic [15:0] head_payload,
    input  wire logic [11:0] head_grade,
    input  wire logic [7:0]  head_courses,
    input  wire logic [15:0] head_priority,
    input  wire logic [6:0]  occupancy,
    input  wire logic        queue_empty,
    input  wire logic [1:0]  status,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [15:0] payload;
        logic [11:0] grade;
        logic [7:0]  courses;
        logic [15:0] prio;
        logic [6:0]  occ;
        logic        empty;
        logic [1:0]  st;
    } report_t;

    entry_t      shadow_q[$];
    report_t     expected_reports[$];
    logic [11:0] grade_max;
    logic [7:0]  course_total;

    assign pending = expected_reports.size();

    function automatic logic [15:0] grade_course_prio(logic [11:0] g, logic [7:0] c);
        longint unsigned gm, cm, gg, cc, q;
        gm = (grade_max == 0) ? 1 : grade_max;
        cm = (course_total == 0) ? 1 : course_total;
        gg = (g > gm) ? gm : g;
        cc = (c > cm) ? cm : c;
        q = ((gg * cm + cc * gm) << 15) / (gm * cm);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    task automatic apply_request();
        entry_t  e;
        report_t r;
        int      pos;
        r.st = ST_OK;
        if (req_type == REQ_ENQ) begin
            if (shadow_q.size() >= DEPTH) r.st = ST_FULL;
            else
            begin
                e.payload = payload;
                e.grade = avg_grade;
                e.courses = courses_passed;
                e.prio = grade_course_prio(avg_grade, courses_passed);
                pos = 0;
                while (pos < shadow_q.size() && shadow_q[pos].prio >= e.prio) pos++;
                shadow_q.insert(pos, e);
            end
        end
        else if (shadow_q.size() == 0) r.st = ST_EMPTY;
        else void'(shadow_q.pop_front());
        if (shadow_q.size() > 0)
        begin
            r.payload = shadow_q[0].payload;
            r.grade = shadow_q[0].grade;
            r.courses = shadow_q[0].courses;
            r.prio = shadow_q[0].prio;
        end
        else
        begin
            r.payload = 0;
            r.grade = 0;
            r.courses = 0;
            r.prio = 0;
        end
        r.occ = 7'(shadow_q.size());
        r.empty = (shadow_q.size() == 0);
        expected_reports.push_back(r);
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic compare_report();
        report_t r;
        if (expected_reports.size() == 0)
        begin
            $error("result transfer with no expected result");
            fail_count++;
        end
        else
        begin
            r = expected_reports.pop_front();
            check_field("head_payload", r.payload, head_payload);
            check_field("head_grade", r.grade, head_grade);
            check_field("head_courses", r.courses, head_courses);
            check_field("head_priority", r.prio, head_priority);
            check_field("occupancy", r.occ, occupancy);
            check_field("queue_empty", r.empty, queue_empty);
            check_field("status", r.st, status);
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_q.delete();
            expected_reports.delete();
            grade_max = MAX_GRADE_RST;
            course_total = TOTAL_COURSES_RST;
        end
        else
        begin
            if (done) compare_report();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_GRADE) grade_max = cfg_data;
                else course_total = cfg_data[7:0];
            end
            if (start && !busy) apply_request();
        end
    end
endmodule

// File: test/tb_top.sv
// testbench top: drives commands and register writes into the priority queue, gives the verdict
`timescale 1ns / 100ps
module tb_top;
    import spq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        req_type = REQ_ENQ;
    logic [15:0] payload = '0;
    logic [11:0] avg_grade = '0;
    logic [7:0]  courses_passed = '0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = CFG_MAX_GRADE;
    logic [11:0] cfg_data = '0;
    logic        busy, cfg_ready, done, queue_empty;
    logic [15:0] head_payload, head_priority;
    logic [11:0] head_grade;
    logic [7:0]  head_courses;
    logic [6:0]  occupancy;
    logic [1:0]  status;
    int          fail_count, pending;
    int          idle_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sorted_priority_queue u_top (.*);

    spq_checker u_chk (.*);

    initial
    begin
        #20000000;
        $display("tb_top failed");
        $finish;
    end

    task automatic send_request(logic rt, logic [15:0] p, logic [11:0] g, logic [7:0] c);
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        start <= 1'b1;
        req_type <= rt;
        payload <= p;
        avg_grade <= g;
        courses_passed <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [11:0] v);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // bias grades and courses toward the configured limits, ties and extremes
    task automatic random_phase(int n, int pct, int enq_bias);
        logic [11:0] g;
        logic [7:0]  c;
        idle_pct = pct;
        repeat (n)
        begin
            case ($urandom_range(3))
                0: g = 12'($urandom);
                1: g = 12'($urandom_range(3) * 640);
                default: g = 12'($urandom_range(2600));
            endcase
            c = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(45));
            send_request(($urandom_range(99) < enq_bias) ? REQ_ENQ : REQ_DEQ,
                         16'($urandom), g, c);
        end
    endtask

    initial
    begin
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty dequeue, extremes, ties, saturation
        send_request(REQ_DEQ, 16'hFFFF, 12'hFFF, 8'hFF);
        send_request(REQ_ENQ, 16'h0000, 12'd0, 8'd0);
        send_request(REQ_ENQ, 16'hFFFF, 12'hFFF, 8'hFF);
        send_request(REQ_ENQ, 16'hA5A5, 12'd2560, 8'd40);
        send_request(REQ_ENQ, 16'h5A5A, 12'd1280, 8'd20);
        send_request(REQ_ENQ, 16'h1234, 12'd1280, 8'd20);
        repeat (6) send_request(REQ_DEQ, 16'h0, 12'h0, 8'h0);
        // fill past full
        repeat (66) send_request(REQ_ENQ, 16'($urandom), 12'($urandom), 8'($urandom));
        repeat (64) send_request(REQ_DEQ, 16'h0, 12'h0, 8'h0);
        random_phase(300, 0, 55);
        write_reg(CFG_MAX_GRADE, 12'd4095);
        write_reg(CFG_TOTAL, 12'd255);
        random_phase(300, 80, 60);
        write_reg(CFG_MAX_GRADE, 12'd0);
        write_reg(CFG_TOTAL, 12'd0);
        random_phase(250, 13, 50);
        write_reg(CFG_MAX_GRADE, 12'd1);
        write_reg(CFG_TOTAL, 12'd1);
        random_phase(200, 0, 75);
        write_reg(CFG_MAX_GRADE, 12'($urandom_range(1, 4095)));
        write_reg(CFG_TOTAL, 12'hF00 | 12'($urandom_range(1, 255)));
        random_phase(250, 80, 40);
        write_reg(CFG_MAX_GRADE, MAX_GRADE_RST);
        write_reg(CFG_TOTAL, {4'h0, TOTAL_COURSES_RST});
        random_phase(200, 13, 55);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule

// File: filelist.f
design/spq_pkg.sv
design/sorted_priority_queue.sv
test/spq_checker.sv
test/tb_top.sv
